[rtl/core/rrqs_pkg.sv]
`timescale 1ns / 1ps

package rrqs_pkg;

	// event codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_ENTRY = 2'd1;
	localparam logic [1:0] FUNC_EXIT  = 2'd2;

	localparam int ID_W      = 6;
	localparam int MASK_W    = 64;
	localparam int QUANTUM_W = 16;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd1000;
	localparam logic [QUANTUM_W-1:0] COUNT_MAX     = 16'hFFFF;
	localparam logic [ID_W-1:0]      KERNEL_ID     = 6'd0;

	typedef struct packed {
		logic [1:0]        func;
		logic [MASK_W-1:0] ready_mask;
	} rrqs_in_t;

	typedef struct packed {
		logic [ID_W-1:0] running_id;
		logic [ID_W-1:0] picked_id;
		logic            picked_now;
		logic            requeue_valid;
		logic [ID_W-1:0] requeue_id;
		logic            unexpected_current;
	} rrqs_out_t;

endpackage

[rtl/core/round_robin_quantum_scheduler_core.sv]
`timescale 1ns / 1ps

// round-robin process scheduler with a time quantum. each item is one event
// (tick, kernel entry, kernel exit) with the ready bits of processes
// 1..NUM_PROCS-1; id 0 is the kernel. every item gives exactly one result item.
// the item is captured in an input register, then the whole event (quantum
// count, rotate-and-priority pick over the ready bits, context switch) is
// resolved into the result register, so one item is taken per cycle when the
// output does not stall. a result is offered from the result register once its
// item has passed the input register, and is taken when out_stall is low.
// the input register can still take one item while a finished result waits on
// a stalled output; in_stall only rises once both registers are full. quantum_q
// is written through cfg_wr_en / cfg_wr_data while the block is idle, a rule
// for the user that the block itself does not enforce; it resets to 1000 and
// the quantum ends on the counted tick at which the count reaches or passes it
module round_robin_quantum_scheduler_core #(
	parameter int NUM_PROCS = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  rrqs_pkg::rrqs_in_t                      in_item,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output rrqs_pkg::rrqs_out_t                     out_item,
	input  logic                                    cfg_wr_en,
	input  logic [rrqs_pkg::QUANTUM_W-1:0]          cfg_wr_data
);

	// user processes occupy ids 1..SPAN
	localparam int SPAN  = NUM_PROCS - 1;
	localparam int IDX_W = (SPAN > 1) ? $clog2(SPAN) : 1;
	localparam logic [rrqs_pkg::ID_W-1:0] SPAN_ID = rrqs_pkg::ID_W'(SPAN);

	// input register
	logic               valid_s1;
	rrqs_pkg::rrqs_in_t item_s1;

	// result register
	logic                out_valid_q;
	rrqs_pkg::rrqs_out_t out_q;

	// scheduler state
	logic [rrqs_pkg::QUANTUM_W-1:0] quantum_q;
	logic [rrqs_pkg::ID_W-1:0]      prev_q;
	logic [rrqs_pkg::ID_W-1:0]      running_q;
	logic [rrqs_pkg::ID_W-1:0]      chosen_q;
	logic [rrqs_pkg::QUANTUM_W-1:0] count_q;
	logic                           counting_q;

	logic s1_move;
	logic in_take;

	// result register frees up when empty or being taken
	assign s1_move  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !s1_move;
	assign in_take  = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// round-robin pick: first ready id at or after the start slot, else wrap
	logic [SPAN-1:0]                ready_span;
	logic [IDX_W-1:0]               start_idx;
	logic                           hit_hi, hit_any;
	logic [IDX_W-1:0]               idx_hi, idx_any;
	logic [rrqs_pkg::ID_W-1:0]      pick_id;

	assign ready_span = item_s1.ready_mask[SPAN:1];
	// slot after the last process, wrapping back to id 1 past the top
	assign start_idx  = (prev_q >= SPAN_ID) ? '0 : prev_q[IDX_W-1:0];

	always_comb begin
		hit_hi  = 1'b0;
		hit_any = 1'b0;
		idx_hi  = '0;
		idx_any = '0;
		// walk downwards so the lowest set slot is the one kept
		for (int j = SPAN - 1; j >= 0; j--) begin
			if (ready_span[j]) begin
				hit_any = 1'b1;
				idx_any = IDX_W'(j);
				if (IDX_W'(j) >= start_idx) begin
					hit_hi = 1'b1;
					idx_hi = IDX_W'(j);
				end
			end
		end
		if (hit_hi) begin
			pick_id = rrqs_pkg::ID_W'(idx_hi) + rrqs_pkg::ID_W'(1);
		end else if (hit_any) begin
			pick_id = rrqs_pkg::ID_W'(idx_any) + rrqs_pkg::ID_W'(1);
		end else begin
			pick_id = rrqs_pkg::KERNEL_ID;
		end
	end

	// event resolution
	logic [rrqs_pkg::QUANTUM_W-1:0] count_inc;
	logic                           quantum_end;
	logic                           do_switch;
	logic [rrqs_pkg::ID_W-1:0]      target_id;
	logic                           picked_now;
	logic                           unexpected;

	// saturating increment
	assign count_inc   = (count_q != rrqs_pkg::COUNT_MAX) ? count_q + 16'd1 : count_q;
	assign quantum_end = (count_inc >= quantum_q);

	always_comb begin
		do_switch  = 1'b0;
		target_id  = rrqs_pkg::KERNEL_ID;
		picked_now = 1'b0;
		unexpected = 1'b0;
		case (item_s1.func)
			rrqs_pkg::FUNC_TICK: begin
				picked_now = counting_q && quantum_end;
			end
			rrqs_pkg::FUNC_ENTRY: begin
				// kernel entry while the kernel runs is no switch
				do_switch = (running_q != rrqs_pkg::KERNEL_ID);
				target_id = rrqs_pkg::KERNEL_ID;
			end
			rrqs_pkg::FUNC_EXIT: begin
				// exit still switches when a process is current, but flags it
				do_switch  = 1'b1;
				target_id  = chosen_q;
				unexpected = (running_q != rrqs_pkg::KERNEL_ID);
			end
			default: begin
				// unused event code: state holds, flags stay low
			end
		endcase
	end

	logic step;
	assign step = valid_s1 && s1_move;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_move || !valid_s1) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= rrqs_pkg::QUANTUM_RESET;
		end else if (cfg_wr_en) begin
			quantum_q <= cfg_wr_data;
		end
	end

	// scheduler state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= rrqs_pkg::KERNEL_ID;
			running_q  <= rrqs_pkg::KERNEL_ID;
			chosen_q   <= rrqs_pkg::KERNEL_ID;
			count_q    <= '0;
			counting_q <= 1'b0;
		end else if (step) begin
			if (item_s1.func == rrqs_pkg::FUNC_TICK && counting_q) begin
				count_q <= count_inc;
				if (quantum_end) begin
					counting_q <= 1'b0;
					chosen_q   <= pick_id;
				end
			end
			if (do_switch) begin
				if (running_q != rrqs_pkg::KERNEL_ID) begin
					prev_q <= running_q;
				end
				count_q    <= '0;
				running_q  <= target_id;
				counting_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q.running_id         <= do_switch ? target_id : running_q;
			out_q.picked_id          <= picked_now ? pick_id : chosen_q;
			out_q.picked_now         <= picked_now;
			out_q.requeue_valid      <= do_switch;
			out_q.requeue_id         <= do_switch ? running_q : rrqs_pkg::KERNEL_ID;
			out_q.unexpected_current <= unexpected;
		end
	end

`ifndef SYNTHESIS
	// a quantum end is a tick, never a switch
	a_pick_no_switch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.picked_now |-> !out_item.requeue_valid &&
			!out_item.unexpected_current)
		else $error("pick and switch reported for one item");

	// requeue id is clear when no switch happened
	a_requeue_id_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.requeue_valid |-> out_item.requeue_id == rrqs_pkg::KERNEL_ID)
		else $error("requeue id set without a switch");

	// a process leaving on kernel entry becomes the round-robin anchor
	a_entry_prev: assert property (@(posedge clk) disable iff (!arst_n)
		step && item_s1.func == rrqs_pkg::FUNC_ENTRY && running_q != rrqs_pkg::KERNEL_ID
		|=> prev_q == $past(running_q) && running_q == rrqs_pkg::KERNEL_ID)
		else $error("kernel entry did not record the outgoing process");

	// picked and running ids stay within the kernel and user process range
	a_chosen_range: assert property (@(posedge clk) disable iff (!arst_n)
		chosen_q <= SPAN_ID && running_q <= SPAN_ID)
		else $error("process id out of range");

	// a quantum end stops counting
	a_quantum_stops: assert property (@(posedge clk) disable iff (!arst_n)
		step && picked_now |=> !counting_q)
		else $error("counting still on after quantum end");
`endif

endmodule
